>>> hdl/tczb_pkg.sv
// Shared types and constants for the touch channel zone binder.
`default_nettype none
package tczb_pkg;

	localparam int TOUCH_W = 36;
	localparam int IN_W    = 56;

	localparam logic [2:0] KIND_SCAN  = 3'd0;
	localparam logic [2:0] KIND_BIND  = 3'd1;
	localparam logic [2:0] KIND_ABORT = 3'd2;
	localparam logic [2:0] KIND_SET   = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [7:0] UNBOUND = 8'hFF;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic cmd_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_scan;
		logic cnt_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> hdl/tczb_ctrl.sv
// Sequencing state machine: accept, zone sweep or command read, result commit.
`default_nettype none
module tczb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire tczb_pkg::sts_t sts,
	output tczb_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_CMD   = 5'b01000,
		ST_RES   = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = sts.in_scan ? ST_SCAN : ST_CMD;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.cnt_last) begin
					state_nx = ST_DRAIN;
				end
			end
			// last zone read is still being evaluated
			ST_DRAIN: begin
				state_nx = ST_RES;
			end
			ST_CMD: begin
				cmd.cmd_rd = 1'b1;
				state_nx   = ST_RES;
			end
			ST_RES: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

>>> hdl/tczb_dpath.sv
// Datapath: input word, zone table, sweep counter, learn state, output word.
`default_nettype none
module tczb_dpath #(
	parameter int ZONES    = 34,
	parameter int CHANNELS = 36
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tczb_pkg::cmd_t               cmd,
	output tczb_pkg::sts_t                    sts,
	input  wire logic [tczb_pkg::IN_W-1:0]    s_tdata,
	input  wire logic [2:0]                   s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [ZONES-1:0]                  zone_hits,
	output logic [1:0]                        status,
	output logic                              bind_done,
	output logic [5:0]                        bound_zone,
	output logic [5:0]                        bound_channel,
	output logic [7:0]                        entry_value
);

	localparam int ZW  = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int TW  = tczb_pkg::TOUCH_W;
	localparam int LIM = (CHANNELS < TW) ? CHANNELS : TW;
	localparam logic [TW-1:0] CH_MASK = {TW{1'b1}} >> (TW - LIM);
	localparam logic [7:0] CH8 = 8'(CHANNELS);
	localparam logic [7:0] Z8  = 8'(ZONES);

	function automatic logic [5:0] lowest_of(input logic [TW-1:0] t);
		logic [5:0] idx;
		idx = '0;
		for (int i = TW - 1; i >= 0; i--) begin
			if (t[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

	// captured input word
	logic [2:0]    kind_q;
	logic [TW-1:0] touch_q;
	logic          link_q;
	logic [1:0]    plen_q;
	logic [7:0]    zone_q;
	logic [7:0]    chan_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= s_tuser;
			touch_q <= s_tdata[TW-1:0];
			link_q  <= s_tdata[36];
			plen_q  <= s_tdata[38:37];
			zone_q  <= s_tdata[46:39];
			chan_q  <= s_tdata[54:47];
		end
	end

	// zone table: entries without a valid bit read as unbound
	logic [7:0]       mem [ZONES];
	logic [ZONES-1:0] valid_q;
	logic             wr_en;
	logic [ZW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [ZW-1:0]    rd_addr;
	logic [7:0]       rd_data_s1;
	logic             rd_vld_s1;
	logic             eval_s1;
	logic [ZW-1:0]    zone_s1;
	logic [ZW-1:0]    cnt_q;
	logic             zone_ok;

	assign zone_ok = zone_q < Z8;
	assign rd_en   = cmd.scan_rd | (cmd.cmd_rd & zone_ok);
	assign rd_addr = cmd.scan_rd ? cnt_q : zone_q[ZW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= valid_q[rd_addr];
		end
		zone_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			eval_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.commit && wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			eval_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	logic [7:0]  eff;
	logic [63:0] touch64;
	logic        hit;

	assign eff     = rd_vld_s1 ? rd_data_s1 : tczb_pkg::UNBOUND;
	assign touch64 = 64'(touch_q);
	assign hit     = (eff < CH8) && touch64[eff[5:0]];

	logic [ZONES-1:0] area_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			area_q <= '0;
		end else if (eval_s1) begin
			area_q[zone_s1] <= hit;
		end
	end

	// learn state
	logic       learning_q;
	logic [5:0] target_q;
	logic       learn_set;
	logic       learn_clr;

	logic [TW-1:0] usable;
	logic          found;
	logic [5:0]    lowest;

	assign usable = touch_q & CH_MASK;
	assign found  = |usable;
	assign lowest = lowest_of(usable);

	// result of the held item
	logic [ZONES-1:0] res_area;
	logic [1:0]       res_stat;
	logic             res_done;
	logic [5:0]       res_bz;
	logic [5:0]       res_bc;
	logic [7:0]       res_entry;

	always_comb begin
		res_area  = '0;
		res_stat  = tczb_pkg::STAT_OK;
		res_done  = 1'b0;
		res_bz    = '0;
		res_bc    = '0;
		res_entry = '0;
		wr_en     = 1'b0;
		wr_addr   = zone_q[ZW-1:0];
		wr_data   = (chan_q >= CH8) ? tczb_pkg::UNBOUND : chan_q;
		learn_set = 1'b0;
		learn_clr = 1'b0;
		case (kind_q)
			tczb_pkg::KIND_SCAN: begin
				res_area = area_q;
				if (learning_q && link_q && found) begin
					res_done  = 1'b1;
					res_bz    = target_q;
					res_bc    = lowest;
					learn_clr = 1'b1;
					wr_addr   = target_q[ZW-1:0];
					wr_data   = {2'b00, lowest};
					wr_en     = {2'b00, target_q} < Z8;
				end
			end
			tczb_pkg::KIND_BIND: begin
				if (plen_q < 2'd1) begin
					res_stat = tczb_pkg::STAT_SHORT;
				end else if (!zone_ok) begin
					res_stat = tczb_pkg::STAT_RANGE;
				end else begin
					learn_set = 1'b1;
				end
			end
			tczb_pkg::KIND_ABORT: begin
				learn_clr = 1'b1;
			end
			tczb_pkg::KIND_SET: begin
				if (plen_q < 2'd2) begin
					res_stat = tczb_pkg::STAT_SHORT;
				end else if (!zone_ok) begin
					res_stat = tczb_pkg::STAT_RANGE;
				end else begin
					wr_en = 1'b1;
				end
			end
			tczb_pkg::KIND_READ: begin
				if (plen_q < 2'd1) begin
					res_stat = tczb_pkg::STAT_SHORT;
				end else if (!zone_ok) begin
					res_stat = tczb_pkg::STAT_RANGE;
				end else begin
					res_entry = eff;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_q <= 1'b0;
			target_q   <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cmd.commit && learn_clr) begin
				learning_q <= 1'b0;
			end else if (cmd.commit && learn_set) begin
				learning_q <= 1'b1;
				target_q   <= zone_q[5:0];
			end
			if (cmd.commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			zone_hits     <= res_area;
			status        <= res_stat;
			bind_done     <= res_done;
			bound_zone    <= res_bz;
			bound_channel <= res_bc;
			entry_value   <= res_entry;
		end
	end

	assign sts.in_scan  = (s_tuser == tczb_pkg::KIND_SCAN);
	assign sts.cnt_last = (cnt_q == ZW'(ZONES - 1));
	assign sts.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire

>>> hdl/touch_channel_zone_binder.sv
// Touch channel zone binder top level.
// Scan tick: a sweep of the zone table (one table read per zone), then the result word.
// Other commands: the command state, then the result state, before the result word.
// One item at a time; a new word is taken while the previous result waits.
// Async reset: table all unbound (valid bits cleared), learn mode off, no result.
`default_nettype none
module touch_channel_zone_binder #(
	parameter int ZONES    = 34,
	parameter int CHANNELS = 36
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// touch_bits[35:0], link_ok[36], payload_count[38:37], zone_index[46:39],
	// channel_value[54:47], zero pad
	input  wire logic [tczb_pkg::IN_W-1:0]       s_tdata,
	// kind[2:0]
	input  wire logic [2:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// zone_hits[ZONES-1:0], bound_zone, bound_channel, entry_value, zero pad
	output logic [((ZONES + 27) / 8) * 8 - 1:0]  m_tdata,
	// status[1:0], bind_done[2]
	output logic [2:0]                           m_tuser
);

	localparam int OW = ((ZONES + 27) / 8) * 8;

	tczb_pkg::cmd_t cmd;
	tczb_pkg::sts_t sts;

	logic [ZONES-1:0] zone_hits;
	logic [1:0]       status;
	logic             bind_done;
	logic [5:0]       bound_zone;
	logic [5:0]       bound_channel;
	logic [7:0]       entry_value;

	tczb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tczb_dpath #(
		.ZONES    (ZONES),
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.zone_hits     (zone_hits),
		.status        (status),
		.bind_done     (bind_done),
		.bound_zone    (bound_zone),
		.bound_channel (bound_channel),
		.entry_value   (entry_value)
	);

	assign m_tdata = OW'({entry_value, bound_channel, bound_zone, zone_hits});
	assign m_tuser = {bind_done, status};

endmodule
`default_nettype wire

>>> hdl/tczb_checker.sv
// Port-level checks for the touch channel zone binder, bound to the top level.
`default_nettype none
module tczb_checker #(
	parameter int ZONES = 34
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [((ZONES + 27) / 8) * 8 - 1:0] m_tdata,
	input wire logic [2:0]                      m_tuser
);

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// a completed binding always reports ok and a real channel
	a_bind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'd0 && m_tdata[ZONES+11:ZONES+6] < 6'd36)
		else $error("bind event with bad status or channel");

	// no binding: zone and channel fields stay zero
	a_no_bind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata[ZONES+11:ZONES] == 12'd0)
		else $error("bind fields set without a bind event");

	// status code three never appears
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] != 2'd3)
		else $error("undefined status code");

endmodule

bind touch_channel_zone_binder tczb_checker #(
	.ZONES (ZONES)
) u_tczb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
